### hdl/dpec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the disc pair collision block.
// No dependencies; imported by every module of the block except dpec_queue.
package dpec_pkg;

    // Magnitude bits of a center offset that can still be in contact.
    localparam int MAG_W = 16;
    // Bits of the squared distance |d|^2 (sum of two 32-bit squares).
    localparam int NORM_W = 33;
    // Split point of the dot magnitude for the two partial products.
    localparam int SPLIT_W = 24;
    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int CFG_W = 32;
    localparam logic [0:0] REG_CONTACT = 1'b0;
    localparam logic [MAG_W-1:0] CONTACT_RESET = 16'd5120;

    // Outcome of the front end's classification of one pair.
    typedef struct packed {
        logic hit;     // overlapping and approaching
        logic dx_pos;  // offset x is strictly positive
        logic dy_pos;  // offset y is strictly positive
    } cls_t;

endpackage

### hdl/dpec_front.sv
`timescale 1ns / 1ps
// Front end: forms offsets, squared distance and dot product, and decides
// whether a pair collides. Depends on dpec_pkg.
module dpec_front #(
    parameter int W = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [dpec_pkg::MAG_W-1:0] contact,
    input  logic signed [W-1:0]       pos_ax,
    input  logic signed [W-1:0]       pos_ay,
    input  logic signed [W-1:0]       pos_bx,
    input  logic signed [W-1:0]       pos_by,
    input  logic signed [W-1:0]       vel_ax,
    input  logic signed [W-1:0]       vel_ay,
    input  logic signed [W-1:0]       vel_bx,
    input  logic signed [W-1:0]       vel_by,
    output logic                      push,
    output dpec_pkg::cls_t            cls,
    output logic [dpec_pkg::MAG_W-1:0] mag_x,
    output logic [dpec_pkg::MAG_W-1:0] mag_y,
    output logic [W+16:0]             dot_mag,
    output logic [dpec_pkg::NORM_W-1:0] norm,
    output logic signed [W-1:0]       va_x,
    output logic signed [W-1:0]       va_y,
    output logic signed [W-1:0]       vb_x,
    output logic signed [W-1:0]       vb_y
);
    import dpec_pkg::*;

    localparam int EW  = (W + 1 > MAG_W + 1) ? W + 1 : MAG_W + 1;
    localparam int PW  = W + 18;
    localparam int MDW = W + 17;

    logic signed [EW-1:0] dx_c, dy_c;
    logic [EW-1:0]        ax_c, ay_c;
    logic                 near_c;

    logic                 s1_valid_reg, s1_near_reg, s1_dxp_reg, s1_dyp_reg;
    logic [MAG_W-1:0]     s1_mx_reg, s1_my_reg;
    logic signed [MAG_W:0] s1_dx_reg, s1_dy_reg;
    logic signed [W:0]    s1_rvx_reg, s1_rvy_reg;
    logic signed [W-1:0]  s1_vax_reg, s1_vay_reg, s1_vbx_reg, s1_vby_reg;

    logic                 s2_valid_reg, s2_near_reg, s2_dxp_reg, s2_dyp_reg;
    logic [MAG_W-1:0]     s2_mx_reg, s2_my_reg;
    logic [31:0]          s2_sqx_reg, s2_sqy_reg, s2_c2_reg;
    logic signed [PW-1:0] s2_px_reg, s2_py_reg;
    logic signed [W-1:0]  s2_vax_reg, s2_vay_reg, s2_vbx_reg, s2_vby_reg;

    logic signed [PW-1:0] dot_c, neg_c;

    always_comb
    begin
        dx_c = EW'(pos_bx) - EW'(pos_ax);
        dy_c = EW'(pos_by) - EW'(pos_ay);
        ax_c = dx_c[EW-1] ? $unsigned(-dx_c) : $unsigned(dx_c);
        ay_c = dy_c[EW-1] ? $unsigned(-dy_c) : $unsigned(dy_c);
        near_c = (ax_c[EW-1:MAG_W] == '0) && (ay_c[EW-1:MAG_W] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_near_reg <= near_c;
        s1_dxp_reg  <= !dx_c[EW-1] && (ax_c != '0);
        s1_dyp_reg  <= !dy_c[EW-1] && (ay_c != '0);
        s1_mx_reg   <= ax_c[MAG_W-1:0];
        s1_my_reg   <= ay_c[MAG_W-1:0];
        s1_dx_reg   <= dx_c[MAG_W:0];
        s1_dy_reg   <= dy_c[MAG_W:0];
        s1_rvx_reg  <= {vel_bx[W-1], vel_bx} - {vel_ax[W-1], vel_ax};
        s1_rvy_reg  <= {vel_by[W-1], vel_by} - {vel_ay[W-1], vel_ay};
        s1_vax_reg  <= vel_ax;
        s1_vay_reg  <= vel_ay;
        s1_vbx_reg  <= vel_bx;
        s1_vby_reg  <= vel_by;

        s2_near_reg <= s1_near_reg;
        s2_dxp_reg  <= s1_dxp_reg;
        s2_dyp_reg  <= s1_dyp_reg;
        s2_mx_reg   <= s1_mx_reg;
        s2_my_reg   <= s1_my_reg;
        s2_sqx_reg  <= 32'(s1_mx_reg) * 32'(s1_mx_reg);
        s2_sqy_reg  <= 32'(s1_my_reg) * 32'(s1_my_reg);
        s2_c2_reg   <= 32'(contact) * 32'(contact);
        s2_px_reg   <= s1_dx_reg * s1_rvx_reg;
        s2_py_reg   <= s1_dy_reg * s1_rvy_reg;
        s2_vax_reg  <= s1_vax_reg;
        s2_vay_reg  <= s1_vay_reg;
        s2_vbx_reg  <= s1_vbx_reg;
        s2_vby_reg  <= s1_vby_reg;
    end

    // Classification: close enough and moving toward each other.
    always_comb
    begin
        norm  = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
        dot_c = s2_px_reg + s2_py_reg;
        neg_c = -dot_c;
        cls.hit    = s2_near_reg && (norm < {1'b0, s2_c2_reg}) && dot_c[PW-1];
        cls.dx_pos = s2_dxp_reg;
        cls.dy_pos = s2_dyp_reg;
        dot_mag = neg_c[MDW-1:0];
    end

    assign push  = s2_valid_reg;
    assign mag_x = s2_mx_reg;
    assign mag_y = s2_my_reg;
    assign va_x  = s2_vax_reg;
    assign va_y  = s2_vay_reg;
    assign vb_x  = s2_vbx_reg;
    assign vb_y  = s2_vby_reg;

endmodule

### hdl/dpec_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the classifying front end and the response back end.
// No package dependency.
module dpec_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data,
    output logic             full
);
    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_pop;

    assign pop_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push && !full) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### hdl/dpec_back.sv
`timescale 1ns / 1ps
// Back end: forms d*(d.r), divides by |d|^2 one quotient bit per stage, and
// applies the exchange with saturation. Depends on dpec_pkg.
module dpec_back #(
    parameter int W = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid,
    input  dpec_pkg::cls_t             cls,
    input  logic [dpec_pkg::MAG_W-1:0] mag_x,
    input  logic [dpec_pkg::MAG_W-1:0] mag_y,
    input  logic [W+16:0]              dot_mag,
    input  logic [dpec_pkg::NORM_W-1:0] norm,
    input  logic signed [W-1:0]        va_x,
    input  logic signed [W-1:0]        va_y,
    input  logic signed [W-1:0]        vb_x,
    input  logic signed [W-1:0]        vb_y,
    output logic                       done,
    output logic signed [W-1:0]        new_vel_ax,
    output logic signed [W-1:0]        new_vel_ay,
    output logic signed [W-1:0]        new_vel_bx,
    output logic signed [W-1:0]        new_vel_by,
    output logic                       collided,
    output logic                       saturated
);
    import dpec_pkg::*;

    localparam int MDW = W + 17;
    localparam int HW  = MDW - SPLIT_W;
    localparam int NW  = MAG_W + MDW;
    localparam int QW  = W + 1;
    localparam int RW  = NORM_W;

    typedef struct packed {
        cls_t                 cls;
        logic [NORM_W-1:0]    n;
        logic signed [W-1:0]  vax, vay, vbx, vby;
    } pay_t;

    typedef struct packed {
        logic [MAG_W+SPLIT_W-1:0] lox, loy;
        logic [MAG_W+HW-1:0]      hix, hiy;
    } mul_t;

    typedef struct packed {
        logic [RW-1:0] rx, ry;
        logic [QW-1:0] nx, ny;
        logic [QW-1:0] qx, qy;
    } div_t;

    logic  m_valid_reg;
    mul_t  m_reg;
    pay_t  m_pay_reg;

    logic  d_valid_reg [0:QW];
    div_t  d_reg       [0:QW];
    div_t  d_next      [0:QW];
    pay_t  d_pay_reg   [0:QW];

    logic [NW-1:0] numx_c, numy_c;

    // Partial products of |d_c| * |d.r|.
    always_ff @(posedge clk)
    begin
        m_reg.lox <= (MAG_W+SPLIT_W)'(mag_x) * (MAG_W+SPLIT_W)'(dot_mag[SPLIT_W-1:0]);
        m_reg.loy <= (MAG_W+SPLIT_W)'(mag_y) * (MAG_W+SPLIT_W)'(dot_mag[SPLIT_W-1:0]);
        m_reg.hix <= (MAG_W+HW)'(mag_x) * (MAG_W+HW)'(dot_mag[MDW-1:SPLIT_W]);
        m_reg.hiy <= (MAG_W+HW)'(mag_y) * (MAG_W+HW)'(dot_mag[MDW-1:SPLIT_W]);
        m_pay_reg.cls <= cls;
        m_pay_reg.n   <= norm;
        m_pay_reg.vax <= va_x;
        m_pay_reg.vay <= va_y;
        m_pay_reg.vbx <= vb_x;
        m_pay_reg.vby <= vb_y;
    end

    // The quotient fits in QW bits, so the top bits start below the divisor.
    always_comb
    begin
        numx_c = NW'(m_reg.lox) + (NW'(m_reg.hix) << SPLIT_W);
        numy_c = NW'(m_reg.loy) + (NW'(m_reg.hiy) << SPLIT_W);
        d_next[0].rx = RW'(numx_c[NW-1:QW]);
        d_next[0].ry = RW'(numy_c[NW-1:QW]);
        d_next[0].nx = numx_c[QW-1:0];
        d_next[0].ny = numy_c[QW-1:0];
        d_next[0].qx = '0;
        d_next[0].qy = '0;
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_div
            logic [RW:0] sx, sy;
            logic        gx, gy;
            always_comb
            begin
                sx = {d_reg[k].rx, d_reg[k].nx[QW-1]};
                sy = {d_reg[k].ry, d_reg[k].ny[QW-1]};
                gx = (sx >= {1'b0, d_pay_reg[k].n});
                gy = (sy >= {1'b0, d_pay_reg[k].n});
                d_next[k+1].rx = gx ? RW'(sx - {1'b0, d_pay_reg[k].n}) : RW'(sx);
                d_next[k+1].ry = gy ? RW'(sy - {1'b0, d_pay_reg[k].n}) : RW'(sy);
                d_next[k+1].nx = d_reg[k].nx << 1;
                d_next[k+1].ny = d_reg[k].ny << 1;
                d_next[k+1].qx = {d_reg[k].qx[QW-2:0], gx};
                d_next[k+1].qy = {d_reg[k].qy[QW-2:0], gy};
            end
            always_ff @(posedge clk)
            begin
                d_reg[k+1]     <= d_next[k+1];
                d_pay_reg[k+1] <= d_pay_reg[k];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    d_valid_reg[k+1] <= 1'b0;
                else
                    d_valid_reg[k+1] <= d_valid_reg[k];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        d_reg[0]     <= d_next[0];
        d_pay_reg[0] <= m_pay_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            d_valid_reg[0] <= 1'b0;
        end
        else
        begin
            m_valid_reg    <= valid;
            d_valid_reg[0] <= m_valid_reg;
        end
    end

    function automatic logic ovf(input logic signed [W+1:0] v);
        return (v[W+1:W-1] != 3'b000) && (v[W+1:W-1] != 3'b111);
    endfunction

    function automatic logic signed [W-1:0] clip(input logic signed [W+1:0] v);
        if (!ovf(v))
            return v[W-1:0];
        else if (v[W+1])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

    pay_t                fp;
    logic signed [W+1:0] sqx_c, sqy_c, ax_c, ay_c, bx_c, by_c;

    always_comb
    begin
        fp    = d_pay_reg[QW];
        sqx_c = fp.cls.dx_pos ? -$signed((W+2)'(d_reg[QW].qx))
                              : $signed((W+2)'(d_reg[QW].qx));
        sqy_c = fp.cls.dy_pos ? -$signed((W+2)'(d_reg[QW].qy))
                              : $signed((W+2)'(d_reg[QW].qy));
        ax_c  = (W+2)'(fp.vax) + sqx_c;
        ay_c  = (W+2)'(fp.vay) + sqy_c;
        bx_c  = (W+2)'(fp.vbx) - sqx_c;
        by_c  = (W+2)'(fp.vby) - sqy_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= d_valid_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        collided <= fp.cls.hit;
        if (fp.cls.hit)
        begin
            new_vel_ax <= clip(ax_c);
            new_vel_ay <= clip(ay_c);
            new_vel_bx <= clip(bx_c);
            new_vel_by <= clip(by_c);
            saturated  <= ovf(ax_c) || ovf(ay_c) || ovf(bx_c) || ovf(by_c);
        end
        else
        begin
            new_vel_ax <= fp.vax;
            new_vel_ay <= fp.vay;
            new_vel_bx <= fp.vbx;
            new_vel_by <= fp.vby;
            saturated  <= 1'b0;
        end
    end

endmodule

### hdl/disc_pair_elastic_collision.sv
`timescale 1ns / 1ps
// Top level of the equal-mass disc pair collision block: register port,
// front end, queue and back end. Depends on dpec_pkg and all dpec_* modules.
//
// Usage:
//   A beat is a pair of discs (two centers, two velocities) presented on the
//   pos_* and vel_* ports; it is taken at a rising edge with start high and
//   busy low. One beat may be taken every cycle while busy is low.
//   Each beat yields exactly one result beat: new velocities, collided and
//   saturated, shown for one cycle with done high. Results come out in the
//   order the pairs went in, after two front stages, the queue, two multiply
//   stages, the restoring divider, which resolves one quotient bit per stage,
//   and the output register.
//   The receiver cannot stall, so the back end drains the queue every cycle
//   and busy stays low in normal operation.
//   contact_distance sits at byte address 0 of the APB port and must only be
//   written while no pair is in flight. Reset empties the pipeline and the
//   queue and loads contact_distance with 20.0 in Q.8.
module disc_pair_elastic_collision #(
    parameter int VALUE_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpec_pkg::ADDR_W-1:0]     paddr,
    input  logic [dpec_pkg::CFG_W-1:0]      pwdata,
    output logic [dpec_pkg::CFG_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [VALUE_WIDTH-1:0]   pos_ax,
    input  logic signed [VALUE_WIDTH-1:0]   pos_ay,
    input  logic signed [VALUE_WIDTH-1:0]   pos_bx,
    input  logic signed [VALUE_WIDTH-1:0]   pos_by,
    input  logic signed [VALUE_WIDTH-1:0]   vel_ax,
    input  logic signed [VALUE_WIDTH-1:0]   vel_ay,
    input  logic signed [VALUE_WIDTH-1:0]   vel_bx,
    input  logic signed [VALUE_WIDTH-1:0]   vel_by,
    output logic                            done,
    output logic signed [VALUE_WIDTH-1:0]   new_vel_ax,
    output logic signed [VALUE_WIDTH-1:0]   new_vel_ay,
    output logic signed [VALUE_WIDTH-1:0]   new_vel_bx,
    output logic signed [VALUE_WIDTH-1:0]   new_vel_by,
    output logic                            collided,
    output logic                            saturated
);
    import dpec_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int MDW = W + 17;
    localparam int QEW = $bits(cls_t) + 2 * MAG_W + MDW + NORM_W + 4 * W;
    // Edges from acceptance until done is seen high.
    localparam int LAT = W + 7;

    logic [MAG_W-1:0] contact_reg;
    logic             cfg_wr;
    logic             accept;

    // Configuration register; the register index is the word address.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[ADDR_W-1:2] == REG_CONTACT) ? CFG_W'(contact_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            contact_reg <= CONTACT_RESET;
        else if (cfg_wr && (paddr[ADDR_W-1:2] == REG_CONTACT))
            contact_reg <= pwdata[MAG_W-1:0];
    end

    assign accept = start && !busy;

    // Front end to queue.
    logic               f_push;
    cls_t               f_cls;
    logic [MAG_W-1:0]   f_mx, f_my;
    logic [MDW-1:0]     f_md;
    logic [NORM_W-1:0]  f_n;
    logic signed [W-1:0] f_vax, f_vay, f_vbx, f_vby;

    dpec_front #(.W(W)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .contact (contact_reg),
        .pos_ax  (pos_ax),
        .pos_ay  (pos_ay),
        .pos_bx  (pos_bx),
        .pos_by  (pos_by),
        .vel_ax  (vel_ax),
        .vel_ay  (vel_ay),
        .vel_bx  (vel_bx),
        .vel_by  (vel_by),
        .push    (f_push),
        .cls     (f_cls),
        .mag_x   (f_mx),
        .mag_y   (f_my),
        .dot_mag (f_md),
        .norm    (f_n),
        .va_x    (f_vax),
        .va_y    (f_vay),
        .vb_x    (f_vbx),
        .vb_y    (f_vby)
    );

    logic [QEW-1:0]      q_in, q_out;
    logic                q_valid, q_full;
    cls_t                b_cls;
    logic [MAG_W-1:0]    b_mx, b_my;
    logic [MDW-1:0]      b_md;
    logic [NORM_W-1:0]   b_n;
    logic signed [W-1:0] b_vax, b_vay, b_vbx, b_vby;

    assign q_in = {f_cls, f_mx, f_my, f_md, f_n, f_vax, f_vay, f_vbx, f_vby};
    assign {b_cls, b_mx, b_my, b_md, b_n, b_vax, b_vay, b_vbx, b_vby} = q_out;

    dpec_queue #(.WIDTH(QEW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (q_in),
        .pop       (1'b1),
        .pop_valid (q_valid),
        .pop_data  (q_out),
        .full      (q_full)
    );

    assign busy = q_full;

    dpec_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (q_valid),
        .cls        (b_cls),
        .mag_x      (b_mx),
        .mag_y      (b_my),
        .dot_mag    (b_md),
        .norm       (b_n),
        .va_x       (b_vax),
        .va_y       (b_vay),
        .vb_x       (b_vbx),
        .vb_y       (b_vby),
        .done       (done),
        .new_vel_ax (new_vel_ax),
        .new_vel_ay (new_vel_ay),
        .new_vel_bx (new_vel_bx),
        .new_vel_by (new_vel_by),
        .collided   (collided),
        .saturated  (saturated)
    );

    // A result appears a fixed number of cycles after each accepted pair.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("result strobe does not follow accepted pair");

    // No result strobe appears without a matching accepted pair.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without accepted pair");

    // Clipping only happens when the response was applied.
    a_sat_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && !collided |-> !saturated)
        else $error("saturation flagged without collision");

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        f_push |-> !q_full)
        else $error("queue overflow");

endmodule
